@@ rtl/tnrf_pkg.sv @@
`timescale 1ns / 1ps

package tnrf_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int TIME_W    = 32;
    localparam int NONCE_W   = 32;
    localparam int WIN_W     = 16;
    localparam int ENTRY_W   = TIME_W + NONCE_W;

    localparam int IN_W      = 96;
    localparam int OUT_W     = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd300;
    localparam logic             REG_WINDOW   = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_WINDOW = 2'd1,
        STATUS_DUP    = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PURGE_RD,
        ST_PURGE_CHK,
        ST_WIN,
        ST_SCAN,
        ST_DONE
    } state_t;

    function automatic logic within_window(
        input logic [TIME_W-1:0] t,
        input logic [TIME_W-1:0] now,
        input logic [WIN_W-1:0]  win
    );
        logic [TIME_W-1:0] d;
        begin
            d = (now >= t) ? (now - t) : (t - now);
            within_window = (d < {{(TIME_W-WIN_W){1'b0}}, win});
        end
    endfunction

endpackage

@@ rtl/timestamp_nonce_replay_filter.sv @@
`timescale 1ns / 1ps

// Replay filter for authenticated requests.
// Input beat (s_*): current_time, request_time and nonce. Output beat (m_*):
// accepted, status (ok, outside window, duplicate, log full) and the number
// of entries left in the log. Each input beat yields exactly one output beat.
// The window width is set through the APB register at address 0.
// The log is a 64-entry synchronous memory of {time, nonce} with one read
// port and one write port. An item first walks expired entries from the
// oldest end (a memory read state and a compare state for each entry looked
// at), then checks the request window, then streams the live entries
// through the read port at one entry per cycle (skipped for a request
// outside the window), and finally loads the output register. One item is
// worked on at a time, and the memory read port sets the pace. A new beat
// is taken as soon as the result sits in the output register, so a stalled
// receiver holds only the result, not the input, until the second result
// is ready. Reset empties the log, sets the window to 300 and drops any
// pending beat; no clearing pass is needed.
module timestamp_nonce_replay_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] current_time, [63:32] request_time, [95:64] nonce
    input  logic [tnrf_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] accepted, [2:1] status, [9:3] log_entries, [15:10] zero
    output logic [tnrf_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tnrf_pkg::PADDR_W-1:0]  paddr,
    input  logic [tnrf_pkg::PDATA_W-1:0]  pwdata,
    output logic [tnrf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tnrf_pkg::*;

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    window_reg;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   req_reg, req_next;
    logic [NONCE_W-1:0]  nonce_reg, nonce_next;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                rd_vld_reg, rd_vld_next;
    status_t             status_reg, status_next;

    logic                out_vld_reg, out_vld_next;
    logic                out_acc_reg, out_acc_next;
    status_t             out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;

    logic [ENTRY_W-1:0]  mem [LOG_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_en;
    logic                issue;
    logic                match;
    logic                head_live;
    logic                req_live;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);
    assign prdata = (paddr[2] == REG_WINDOW)
                    ? {{(PDATA_W-WIN_W){1'b0}}, window_reg} : '0;

    assign issue     = (k_reg < count_reg);
    assign match     = rd_vld_reg && (rd_data_reg[ENTRY_W-1:NONCE_W] == req_reg)
                       && (rd_data_reg[NONCE_W-1:0] == nonce_reg);
    assign head_live = within_window(rd_data_reg[ENTRY_W-1:NONCE_W], now_reg, window_reg);
    assign req_live  = within_window(req_reg, now_reg, window_reg);
    assign wr_addr   = oldest_reg + count_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        req_next        = req_reg;
        nonce_next      = nonce_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        rd_vld_next     = 1'b0;
        status_next     = status_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_acc_next    = out_acc_reg;
        out_status_next = out_status_reg;
        out_cnt_next    = out_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next   = s_tdata[TIME_W-1:0];
                    req_next   = s_tdata[2*TIME_W-1:TIME_W];
                    nonce_next = s_tdata[IN_W-1:2*TIME_W];
                    state_next = ST_PURGE_RD;
                end
            end
            ST_PURGE_RD: begin
                state_next = (count_reg == '0) ? ST_WIN : ST_PURGE_CHK;
            end
            ST_PURGE_CHK: begin
                if (!head_live) begin
                    oldest_next = oldest_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_PURGE_RD;
                end else begin
                    state_next  = ST_WIN;
                end
            end
            ST_WIN: begin
                k_next = '0;
                if (!req_live) begin
                    status_next = STATUS_WINDOW;
                    state_next  = ST_DONE;
                end else begin
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    k_next = k_reg + 1'b1;
                end
                if (match) begin
                    status_next = STATUS_DUP;
                    state_next  = ST_DONE;
                end else if (!issue && !rd_vld_reg) begin
                    if (count_reg == CNT_W'(LOG_DEPTH)) begin
                        status_next = STATUS_FULL;
                    end else begin
                        status_next = STATUS_OK;
                        count_next  = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next    = 1'b1;
                    out_acc_next    = (status_reg == STATUS_OK);
                    out_status_next = status_reg;
                    out_cnt_next    = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_addr  = oldest_reg;
        wr_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_PURGE_RD:  rd_addr  = oldest_reg;
            ST_SCAN: begin
                rd_addr = oldest_reg + k_reg[IDX_W-1:0];
                wr_en   = !match && !issue && !rd_vld_reg
                          && (count_reg != CNT_W'(LOG_DEPTH));
            end
            default: rd_addr = oldest_reg;
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_W-CNT_W-3){1'b0}}, out_cnt_reg, out_status_reg, out_acc_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {req_reg, nonce_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            oldest_reg  <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            status_reg  <= STATUS_OK;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            rd_vld_reg  <= rd_vld_next;
            status_reg  <= status_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr) begin
                window_reg <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        req_reg        <= req_next;
        nonce_reg      <= nonce_next;
        out_acc_reg    <= out_acc_next;
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LOG_DEPTH))
        else $error("log count above depth");

    a_acc_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_acc_reg == (out_status_reg == STATUS_OK)))
        else $error("accepted flag disagrees with status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && (out_status_reg == STATUS_FULL)) |-> (out_cnt_reg == CNT_W'(LOG_DEPTH)))
        else $error("full status with log not full");

    a_write_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("log write without count increment");
`endif

endmodule

@@ tb/sv/tb_timestamp_nonce_replay_filter.sv @@
`timescale 1ns / 1ps

module tb_timestamp_nonce_replay_filter;

    import tnrf_pkg::*;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW, 2'b00};
    localparam int                 HISTORY     = 32;

    typedef struct packed {
        logic             accepted;
        status_t          status;
        logic [CNT_W-1:0] entries;
    } verdict_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] current_time, [63:32] request_time, [95:64] nonce
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] accepted, [2:1] status, [9:3] log_entries, [15:10] zero
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Mirror of the filter state
    logic [WIN_W-1:0]     window_m = WINDOW_RESET;
    logic [TIME_W-1:0]    stamp_m [LOG_DEPTH];
    logic [NONCE_W-1:0]   nonce_m [LOG_DEPTH];
    int unsigned          head_m   = 0;
    int unsigned          live_m   = 0;

    verdict_t             expected_verdicts[$];
    verdict_t             head_verdict;
    int unsigned          mismatches = 0;

    logic                 quiet    = 1'b0;
    int unsigned          rx_hold  = 0;
    logic [TIME_W-1:0]    clock_s  = '0;
    logic [TIME_W-1:0]    seen_time  [HISTORY];
    logic [NONCE_W-1:0]   seen_nonce [HISTORY];
    int unsigned          seen_wr  = 0;
    int unsigned          seen_n   = 0;

    timestamp_nonce_replay_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(50_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic logic time_is_fresh(input logic [TIME_W-1:0] t,
                                           input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] delta;
        delta = (now >= t) ? now - t : t - now;
        return delta < {{(TIME_W-WIN_W){1'b0}}, window_m};
    endfunction

    function automatic verdict_t judge_request(input logic [TIME_W-1:0]  now,
                                               input logic [TIME_W-1:0]  req,
                                               input logic [NONCE_W-1:0] non);
        verdict_t    v;
        int unsigned slot;
        v.status = STATUS_OK;
        while (live_m != 0 && !time_is_fresh(stamp_m[head_m], now)) begin
            head_m = (head_m + 1) % LOG_DEPTH;
            live_m--;
        end
        if (!time_is_fresh(req, now)) begin
            v.status = STATUS_WINDOW;
        end else begin
            for (int k = 0; k < live_m; k++) begin
                slot = (head_m + k) % LOG_DEPTH;
                if (stamp_m[slot] == req && nonce_m[slot] == non) begin
                    v.status = STATUS_DUP;
                    break;
                end
            end
            if (v.status == STATUS_OK && live_m >= LOG_DEPTH)
                v.status = STATUS_FULL;
        end
        if (v.status == STATUS_OK) begin
            slot = (head_m + live_m) % LOG_DEPTH;
            stamp_m[slot] = req;
            nonce_m[slot] = non;
            live_m++;
        end
        v.accepted = (v.status == STATUS_OK);
        v.entries  = CNT_W'(live_m);
        return v;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(40, 150);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (quiet || $urandom_range(0, 99) < 65) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold = idle_len();
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(m_tdata), 32'd0);
            end else begin
                head_verdict = expected_verdicts.pop_front();
                if (m_tdata[0] !== head_verdict.accepted)
                    report_mismatch("accepted", 32'(m_tdata[0]),
                                    32'(head_verdict.accepted));
                if (m_tdata[2:1] !== head_verdict.status)
                    report_mismatch("status", 32'(m_tdata[2:1]),
                                    32'(head_verdict.status));
                if (m_tdata[9:3] !== head_verdict.entries)
                    report_mismatch("log_entries", 32'(m_tdata[9:3]),
                                    32'(head_verdict.entries));
            end
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (addr == WINDOW_ADDR)
            window_m = data[WIN_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_window();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[WIN_W-1:0] !== window_m)
            report_mismatch("window readback", prdata, 32'(window_m));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic offer_request(input logic [TIME_W-1:0]  now,
                                 input logic [TIME_W-1:0]  req,
                                 input logic [NONCE_W-1:0] non);
        int unsigned gap;
        verdict_t    predicted;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {non, req, now};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = judge_request(now, req, non);
        expected_verdicts = {expected_verdicts, predicted};
        seen_time[seen_wr]  = req;
        seen_nonce[seen_wr] = non;
        seen_wr = (seen_wr + 1) % HISTORY;
        if (seen_n < HISTORY)
            seen_n++;
        gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic test_window_edges();
        apb_check_window();
        offer_request(32'd1000, 32'd1000, 32'd1);
        offer_request(32'd1000, 32'd1000, 32'd1);
        offer_request(32'd1000, 32'd1000, 32'd2);
        offer_request(32'd1000, 32'd1299, 32'd3);
        offer_request(32'd1000, 32'd1300, 32'd4);
        offer_request(32'd1000, 32'd701, 32'd5);
        offer_request(32'd1000, 32'd700, 32'd6);
        // drop only the leading stale entries; the older stamp behind them stays
        offer_request(32'd1301, 32'd1301, 32'd10);
        offer_request(32'd1301, 32'd701, 32'd5);
        offer_request(32'd1301, 32'd1299, 32'd3);
    endtask

    task automatic test_wide_times();
        offer_request(32'd0, 32'd0, 32'd7);
        offer_request(32'd0, 32'hFFFF_FFFF, 32'd8);
        offer_request(32'hFFFF_FFFF, 32'd0, 32'd9);
        offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(32'hFFFF_FFFF, 32'hFFFF_FED4, 32'hFFFF_FFFF);
        offer_request(32'hFFFF_FFFF, 32'hFFFF_FED3, 32'd0);
    endtask

    task automatic test_zero_window();
        drain_results();
        apb_write(WINDOW_ADDR, 32'h0000_0000);
        apb_check_window();
        offer_request(32'd5, 32'd5, 32'd1);
        offer_request(32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_spare_register();
        drain_results();
        apb_write(WINDOW_ADDR, 32'hABCD_0040);
        apb_write(SPARE_ADDR, 32'h0000_0007);
        apb_check_window();
        offer_request(32'd100, 32'd163, 32'd1);
        offer_request(32'd100, 32'd164, 32'd2);
        offer_request(32'd100, 32'd37, 32'd3);
        offer_request(32'd100, 32'd36, 32'd4);
    endtask

    task automatic test_log_full();
        drain_results();
        apb_write(WINDOW_ADDR, 32'h0000_FFFF);
        apb_check_window();
        for (int k = 0; k < LOG_DEPTH; k++)
            offer_request(32'h8000_0000, 32'h8000_0000 + k[1:0], $urandom());
        offer_request(32'h8000_0000, 32'h8000_0000, 32'h1234_5678);
        offer_request(32'h8000_0000, seen_time[(seen_wr + HISTORY - 6) % HISTORY],
                      seen_nonce[(seen_wr + HISTORY - 6) % HISTORY]);
        offer_request(32'h8000_0000, 32'h8001_0000, 32'd1);
    endtask

    task automatic test_random_traffic(input logic [WIN_W-1:0] win,
                                       input int unsigned n_items);
        int unsigned       roll;
        int unsigned       span;
        int unsigned       pick;
        logic [TIME_W-1:0]  req;
        logic [NONCE_W-1:0] non;
        drain_results();
        apb_write(WINDOW_ADDR, {16'($urandom()), win});
        apb_check_window();
        span = win;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == n_items / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 60)
                clock_s += $urandom_range(0, 2);
            else if (roll < 85)
                clock_s += $urandom_range(0, span);
            else if (roll < 92)
                clock_s += $urandom_range(span, 2 * span + 5);
            else if (roll < 96)
                clock_s = $urandom();
            else
                clock_s -= $urandom_range(0, span);
            roll = $urandom_range(0, 99);
            non  = $urandom();
            if (roll < 15 && seen_n != 0) begin
                pick = $urandom_range(0, seen_n - 1);
                req  = seen_time[pick];
                non  = seen_nonce[pick];
            end else if (roll < 25) begin
                case ($urandom_range(0, 3))
                    0:       req = clock_s + span - 1;
                    1:       req = clock_s + span;
                    2:       req = clock_s - span + 1;
                    default: req = clock_s - span;
                endcase
            end else if (roll < 33) begin
                req = $urandom();
            end else begin
                req = clock_s + $urandom_range(0, 2 * (span - 1)) - (span - 1);
                if ($urandom_range(0, 3) == 0)
                    non = $urandom_range(0, 3);
            end
            offer_request(clock_s, req, non);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_window_edges();
        test_wide_times();
        test_zero_window();
        test_spare_register();
        test_log_full();
        test_random_traffic(16'd300, 175);
        test_random_traffic(16'd1, 175);
        test_random_traffic(16'hFFFF, 175);
        test_random_traffic(WIN_W'($urandom_range(2, 40)), 175);
        test_random_traffic(WIN_W'($urandom_range(1, 65535)), 175);
        test_random_traffic(16'd1000, 175);

        drain_results();
        repeat (250) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
